FILE: design/utcc_pkg.sv
// Types, operation codes and calendar table for the Unix time calendar converter.
`default_nettype none

package utcc_pkg;

    localparam logic OP_TO_SECONDS  = 1'b0;
    localparam logic OP_TO_CALENDAR = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] unix_seconds;
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [5:0]  cal_second;
    } req_t;

    typedef struct packed {
        logic [31:0] out_seconds;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        clamped;
    } rsp_t;

    // First day-of-year of each March-based month: (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] result;
        case (mp)
            4'd0:    result = 9'd0;
            4'd1:    result = 9'd31;
            4'd2:    result = 9'd61;
            4'd3:    result = 9'd92;
            4'd4:    result = 9'd122;
            4'd5:    result = 9'd153;
            4'd6:    result = 9'd184;
            4'd7:    result = 9'd214;
            4'd8:    result = 9'd245;
            4'd9:    result = 9'd275;
            4'd10:   result = 9'd306;
            4'd11:   result = 9'd337;
            4'd12:   result = 9'd367;
            4'd13:   result = 9'd398;
            4'd14:   result = 9'd428;
            4'd15:   result = 9'd459;
            default: result = 9'd0;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: design/unix_time_calendar_converter.sv
// Top level: pipelined converter between 32-bit Unix seconds and Gregorian date-time.
`default_nettype none

// One request word in, one response word out. Operation 0 turns a calendar
// date-time into seconds since 1970-01-01 00:00:00 (clamped to 0 before the
// epoch, saturated above 32 bits, with clamped set); operation 1 splits
// seconds into year, month, day, hour, minute and second. No time zones, no
// leap seconds, calendar fields are not range checked. The converter is a
// nine-register pipeline (input register, seven arithmetic stages, response
// register): a word is taken every cycle when nothing stalls. The depth is
// set by the chain of constant-reciprocal divisions in the seconds-to-calendar
// path. Stages hold their word under rsp_stall and empty stages keep
// filling, so req_stall rises only when every stage is full.
module unix_time_calendar_converter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire utcc_pkg::req_t req_word,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output utcc_pkg::rsp_t      rsp_word
);
    import utcc_pkg::*;

    localparam int NUM_STAGES = 9;

    localparam logic [25:0] DAY_RECIP     = 26'd50903317;  // 2^35 / 675
    localparam logic [9:0]  ERA_RECIP     = 10'd656;       // 2^14 / 25
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;      // 2^21 / 225
    localparam logic [16:0] QUAD_RECIP    = 17'd91930;     // 2^25 / 365
    localparam logic [10:0] MIN_RECIP     = 11'd1093;      // 2^14 / 15
    localparam logic [18:0] YEAR_RECIP    = 19'd367720;    // 2^27 / 365
    localparam logic [13:0] MONTH_MUL     = 14'd8570;      // 5 * 1714, 2^18 / 153
    localparam logic [11:0] MONTH_ADD     = 12'd3428;      // 2 * 1714
    localparam logic [16:0] DAY_SECONDS   = 17'd86400;
    localparam logic [15:0] ERA5_DAY      = 16'd11017;     // first day of era 5
    localparam logic [17:0] ERA4_OFFSET   = 18'd135080;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [21:0] EPOCH_OFFSET  = 22'd865566;    // biased era, biased day

    typedef struct packed {
        logic        op;
        logic [31:0] u;
        logic [15:0] days;
        logic [12:0] ye;
        logic [3:0]  erap;
        logic [8:0]  doyp;
        logic [16:0] tod;
    } s1_t;

    typedef struct packed {
        logic        op;
        logic [16:0] rem;
        logic        era5;
        logic [17:0] doe;
        logic [8:0]  yoe0;
        logic [3:0]  erap;
        logic [8:0]  doyp;
        logic [16:0] tod;
    } s2_t;

    typedef struct packed {
        logic        op;
        logic [16:0] rem;
        logic [4:0]  hour;
        logic [17:0] doe;
        logic        era5;
        logic [6:0]  dq1460;
        logic [2:0]  dq36524;
        logic        dlast;
        logic [17:0] doep;
        logic [3:0]  erap;
        logic [16:0] tod;
    } s3_t;

    typedef struct packed {
        logic        op;
        logic [11:0] r2;
        logic [4:0]  hour;
        logic [17:0] n;
        logic [17:0] doe;
        logic        era5;
        logic [21:0] days0;
        logic [16:0] tod;
    } s4_t;

    typedef struct packed {
        logic        op;
        logic [11:0] r2;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [8:0]  yoe;
        logic [17:0] doe;
        logic        era5;
        logic [38:0] secs;
    } s5_t;

    typedef struct packed {
        logic        op;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  doy;
        logic [11:0] yr;
        logic [31:0] secs_out;
        logic        clamped;
    } s6_t;

    typedef struct packed {
        logic        op;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [11:0] yr;
        logic [31:0] secs_out;
        logic        clamped;
    } s7_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   ready;

    req_t s0_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    s7_t  s7_reg, s7_next;
    rsp_t s8_reg, s8_next;

    // ---------------- flow control ----------------
    always_comb
    begin
        ready[NUM_STAGES] = !rsp_stall;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign req_stall = !ready[0];
    assign rsp_valid = valid_reg[NUM_STAGES-1];
    assign rsp_word  = s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: days, era, day of year, time of day ----------------
    logic [50:0] day_prod;
    logic [18:0] era_prod;
    logic [3:0]  mp0;

    always_comb
    begin
        day_prod     = 51'(s0_reg.unix_seconds[31:7]) * 51'(DAY_RECIP);
        s1_next.op   = s0_reg.operation;
        s1_next.u    = s0_reg.unix_seconds;
        s1_next.days = day_prod[50:35];
        s1_next.ye   = 13'(s0_reg.cal_year) + 13'd400
                       - 13'(s0_reg.cal_month <= 4'd2);
        era_prod     = 19'(s1_next.ye[12:4]) * 19'(ERA_RECIP);
        s1_next.erap = era_prod[17:14];
        mp0          = (s0_reg.cal_month > 4'd2) ? s0_reg.cal_month - 4'd3
                                                 : s0_reg.cal_month + 4'd9;
        s1_next.doyp = month_start(mp0) + 9'(s0_reg.cal_day);
        s1_next.tod  = 17'(s0_reg.cal_hour) * 17'd3600
                       + 17'(s0_reg.cal_minute) * 17'd60
                       + 17'(s0_reg.cal_second);
    end

    // ---------------- stage 2: second of day, day of era ----------------
    logic [31:0] day_base;

    always_comb
    begin
        day_base     = 32'(s1_reg.days) * 32'(DAY_SECONDS);
        s2_next.op   = s1_reg.op;
        s2_next.rem  = 17'(s1_reg.u - day_base);
        s2_next.era5 = s1_reg.days >= ERA5_DAY;
        s2_next.doe  = s2_next.era5 ? 18'(s1_reg.days) - 18'(ERA5_DAY)
                                    : 18'(s1_reg.days) + ERA4_OFFSET;
        s2_next.yoe0 = 9'(s1_reg.ye - 13'(s1_reg.erap) * 13'd400);
        s2_next.erap = s1_reg.erap;
        s2_next.doyp = s1_reg.doyp;
        s2_next.tod  = s1_reg.tod;
    end

    // ---------------- stage 3: hour, leap corrections ----------------
    logic [26:0] hour_prod;
    logic [33:0] quad_prod;
    logic [1:0]  c100_a;

    always_comb
    begin
        hour_prod       = 27'(s2_reg.rem[16:4]) * 27'(HOUR_RECIP);
        quad_prod       = 34'(s2_reg.doe[17:2]) * 34'(QUAD_RECIP);
        c100_a          = 2'(s2_reg.yoe0 >= 9'd100) + 2'(s2_reg.yoe0 >= 9'd200)
                          + 2'(s2_reg.yoe0 >= 9'd300);
        s3_next.op      = s2_reg.op;
        s3_next.rem     = s2_reg.rem;
        s3_next.hour    = hour_prod[25:21];
        s3_next.doe     = s2_reg.doe;
        s3_next.era5    = s2_reg.era5;
        s3_next.dq1460  = quad_prod[31:25];
        s3_next.dq36524 = 3'(s2_reg.doe >= 18'd36524) + 3'(s2_reg.doe >= 18'd73048)
                          + 3'(s2_reg.doe >= 18'd109572)
                          + 3'(s2_reg.doe >= ERA_LAST_DAY);
        s3_next.dlast   = s2_reg.doe == ERA_LAST_DAY;
        s3_next.doep    = 18'(s2_reg.yoe0) * 18'd365 + 18'(s2_reg.yoe0[8:2])
                          - 18'(c100_a) + 18'(s2_reg.doyp);
        s3_next.erap    = s2_reg.erap;
        s3_next.tod     = s2_reg.tod;
    end

    // ---------------- stage 4: second of hour, year numerator, signed days ----------------
    always_comb
    begin
        s4_next.op    = s3_reg.op;
        s4_next.r2    = 12'(s3_reg.rem - 17'(s3_reg.hour) * 17'd3600);
        s4_next.hour  = s3_reg.hour;
        s4_next.n     = s3_reg.doe - 18'(s3_reg.dq1460) + 18'(s3_reg.dq36524)
                        - 18'(s3_reg.dlast);
        s4_next.doe   = s3_reg.doe;
        s4_next.era5  = s3_reg.era5;
        s4_next.days0 = 22'(s3_reg.erap) * 22'd146097 + 22'(s3_reg.doep)
                        - EPOCH_OFFSET;
        s4_next.tod   = s3_reg.tod;
    end

    // ---------------- stage 5: minute, year of era, total seconds ----------------
    logic [20:0] min_prod;
    logic [36:0] year_prod;

    always_comb
    begin
        min_prod       = 21'(s4_reg.r2[11:2]) * 21'(MIN_RECIP);
        year_prod      = 37'(s4_reg.n) * 37'(YEAR_RECIP);
        s5_next.op     = s4_reg.op;
        s5_next.r2     = s4_reg.r2;
        s5_next.hour   = s4_reg.hour;
        s5_next.minute = min_prod[19:14];
        s5_next.yoe    = year_prod[35:27];
        s5_next.doe    = s4_reg.doe;
        s5_next.era5   = s4_reg.era5;
        s5_next.secs   = 39'($signed({{17{s4_reg.days0[21]}}, s4_reg.days0})
                             * 39'sd86400 + $signed({22'd0, s4_reg.tod}));
    end

    // ---------------- stage 6: second, day of year, year, clamp ----------------
    logic [1:0]  c100_b;
    logic [17:0] year_start;

    always_comb
    begin
        c100_b         = 2'(s5_reg.yoe >= 9'd100) + 2'(s5_reg.yoe >= 9'd200)
                         + 2'(s5_reg.yoe >= 9'd300);
        year_start     = 18'(s5_reg.yoe) * 18'd365 + 18'(s5_reg.yoe[8:2]) - 18'(c100_b);
        s6_next.op     = s5_reg.op;
        s6_next.hour   = s5_reg.hour;
        s6_next.minute = s5_reg.minute;
        s6_next.second = 6'(s5_reg.r2 - 12'(s5_reg.minute) * 12'd60);
        s6_next.doy    = 9'(s5_reg.doe - year_start);
        s6_next.yr     = 12'(s5_reg.yoe) + (s5_reg.era5 ? 12'd2000 : 12'd1600);
        if (s5_reg.secs[38])
        begin
            s6_next.secs_out = '0;
            s6_next.clamped  = 1'b1;
        end
        else if (|s5_reg.secs[37:32])
        begin
            s6_next.secs_out = '1;
            s6_next.clamped  = 1'b1;
        end
        else
        begin
            s6_next.secs_out = s5_reg.secs[31:0];
            s6_next.clamped  = 1'b0;
        end
    end

    // ---------------- stage 7: March-based month ----------------
    logic [21:0] month_prod;

    always_comb
    begin
        month_prod       = 22'(s6_reg.doy) * 22'(MONTH_MUL) + 22'(MONTH_ADD);
        s7_next.op       = s6_reg.op;
        s7_next.hour     = s6_reg.hour;
        s7_next.minute   = s6_reg.minute;
        s7_next.second   = s6_reg.second;
        s7_next.doy      = s6_reg.doy;
        s7_next.mp       = month_prod[21:18];
        s7_next.yr       = s6_reg.yr;
        s7_next.secs_out = s6_reg.secs_out;
        s7_next.clamped  = s6_reg.clamped;
    end

    // ---------------- stage 8: day, civil month, response word ----------------
    logic [3:0] civil_month;

    always_comb
    begin
        civil_month = (s7_reg.mp < 4'd10) ? s7_reg.mp + 4'd3 : s7_reg.mp - 4'd9;
        s8_next     = '0;
        if (s7_reg.op == OP_TO_SECONDS)
        begin
            s8_next.out_seconds = s7_reg.secs_out;
            s8_next.clamped     = s7_reg.clamped;
        end
        else
        begin
            s8_next.out_year   = s7_reg.yr + 12'(civil_month <= 4'd2);
            s8_next.out_month  = civil_month;
            s8_next.out_day    = 5'(s7_reg.doy - month_start(s7_reg.mp) + 9'd1);
            s8_next.out_hour   = s7_reg.hour;
            s8_next.out_minute = s7_reg.minute;
            s8_next.out_second = s7_reg.second;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (ready[0] && req_valid)
        begin
            s0_reg <= req_word;
        end
        if (ready[1] && valid_reg[0])
        begin
            s1_reg <= s1_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            s2_reg <= s2_next;
        end
        if (ready[3] && valid_reg[2])
        begin
            s3_reg <= s3_next;
        end
        if (ready[4] && valid_reg[3])
        begin
            s4_reg <= s4_next;
        end
        if (ready[5] && valid_reg[4])
        begin
            s5_reg <= s5_next;
        end
        if (ready[6] && valid_reg[5])
        begin
            s6_reg <= s6_next;
        end
        if (ready[7] && valid_reg[6])
        begin
            s7_reg <= s7_next;
        end
        if (ready[8] && valid_reg[7])
        begin
            s8_reg <= s8_next;
        end
    end

`ifndef SYNTHESIS
    // input is held off only when the whole pipeline is full
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> &valid_reg)
        else $error("req_stall with an empty pipeline stage");

    // a calendar response never carries seconds or the clamp flag
    a_calendar_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.out_month != 4'd0
        |-> rsp_word.out_seconds == 32'd0 && !rsp_word.clamped)
        else $error("calendar word carries seconds fields");

    // split fields stay in calendar range
    a_calendar_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.out_year != 12'd0
        |-> rsp_word.out_month >= 4'd1 && rsp_word.out_month <= 4'd12
            && rsp_word.out_day >= 5'd1 && rsp_word.out_hour <= 5'd23
            && rsp_word.out_minute <= 6'd59 && rsp_word.out_second <= 6'd59)
        else $error("calendar field out of range");

    // a clamped result is either zero or all ones
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.clamped
        |-> rsp_word.out_seconds == 32'd0 || rsp_word.out_seconds == 32'hFFFF_FFFF)
        else $error("clamped result not at a limit");
`endif

endmodule

`default_nettype wire
